### hw/rtl/page_walk_mmu_with_tlb_macros.svh
// Assertion shorthands for the translation block.
`ifndef PAGE_WALK_MMU_WITH_TLB_MACROS_SVH
`define PAGE_WALK_MMU_WITH_TLB_MACROS_SVH

// Checked at every rising edge, quiet while reset is held.
`define PW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, including during reset.
`define PW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/pwmmu_pkg.sv
package pwmmu_pkg;

  localparam int unsigned TLB_ENTRIES = 4;
  localparam int unsigned TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam int unsigned VA_W     = 48;
  localparam int unsigned PA_W     = 52;
  localparam int unsigned PAGE_W   = 36;
  localparam int unsigned FRAME_W  = 40;
  localparam int unsigned PTE_W    = 64;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned LEVEL_W  = 3;

  // Table entry bit positions
  localparam int unsigned PTE_PRESENT = 0;
  localparam int unsigned PTE_RW      = 1;
  localparam int unsigned PTE_USER    = 2;
  localparam int unsigned PTE_HUGE    = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_TLB = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_1   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_2   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_3   = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_4   = 3'd4;

  typedef enum logic [1:0] {
    ACT_TRANSLATE = 2'd0,
    ACT_PTE       = 2'd1,
    ACT_FLUSH     = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_NOT_PRESENT = 2'd1,
    FAULT_READ_ONLY  = 2'd2,
    FAULT_SUPERVISOR = 2'd3
  } fault_e;

endpackage

### hw/rtl/page_walk_mmu_with_tlb.sv
// An accepted beat that yields a result has it in the output register in the next cycle.
// Throughput: one beat per cycle while the output register is not stalled; a miss walk
// takes one read-request / entry-return round trip per table level, up to four, each set by the external memory.
// Reset (rst_ni low, async): TLB emptied, victim pointer zero, no walk in flight,
// root table base zero, output register empty.
`include "page_walk_mmu_with_tlb_macros.svh"

module page_walk_mmu_with_tlb
  import pwmmu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [PA_W-1:0]  root_table_base_i,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [VA_W-1:0]  virtual_address_i,
  input  logic             is_write_i,
  input  logic             is_user_i,
  input  logic [PTE_W-1:0] pte_data_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [PA_W-1:0]  read_table_base_o,
  output logic [IDX_W-1:0] read_index_o,
  output logic [PA_W-1:0]  physical_address_o,
  output logic [1:0]       fault_code_o,
  output logic [LEVEL_W-1:0] fault_level_o,
  output logic             tlb_hit_o
);

  function automatic fault_e check_perm(input logic [2:0] perm, input logic wr,
                                        input logic usr);
    fault_e code;
    if (!perm[PTE_PRESENT])         code = FAULT_NOT_PRESENT;
    else if (wr && !perm[PTE_RW])   code = FAULT_READ_ONLY;
    else if (usr && !perm[PTE_USER]) code = FAULT_SUPERVISOR;
    else                            code = FAULT_NONE;
    return code;
  endfunction

  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LEVEL_1: idx = va[20:12];
      LEVEL_2: idx = va[29:21];
      LEVEL_3: idx = va[38:30];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

  function automatic logic [VA_W-1:0] level_offset(input logic [VA_W-1:0] va,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [VA_W-1:0] off;
    case (lvl)
      LEVEL_1: off = {36'd0, va[11:0]};
      LEVEL_2: off = {27'd0, va[20:0]};
      LEVEL_3: off = {18'd0, va[29:0]};
      default: off = {9'd0, va[38:0]};
    endcase
    return off;
  endfunction

  // Configuration
  logic [PA_W-1:0] root_q;

  // TLB
  logic [TLB_ENTRIES-1:0] tlb_valid_q, tlb_valid_d;
  logic [PAGE_W-1:0]      tlb_page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
  logic [2:0]             tlb_perm_q  [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0]   victim_q, victim_d;
  logic                   fill_en;

  // Walk state
  logic                 walk_busy_q, walk_busy_d;
  logic [LEVEL_W-1:0]   walk_level_q, walk_level_d;
  logic [VA_W-1:0]      walk_addr_q;
  logic                 walk_write_q, walk_user_q;
  logic                 walk_start;

  // Output register
  logic                 out_valid_q, out_valid_d;
  result_kind_e         kind_q, kind_d;
  logic [PA_W-1:0]      base_q, base_d;
  logic [IDX_W-1:0]     index_q, index_d;
  logic [PA_W-1:0]      pa_q, pa_d;
  fault_e               code_q, code_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic                 hit_q, hit_d;

  logic                 in_accept;
  logic                 res_valid;

  // Combinational helpers
  logic                 hit_any;
  logic [TLB_IDX_W-1:0] hit_idx;
  logic [PAGE_W-1:0]    req_page;
  logic [LEVEL_W-1:0]   lvl;
  fault_e               perm_code;
  logic [PA_W-1:0]      leaf_pa;
  logic [LEVEL_W-1:0]   next_level;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  assign req_page = virtual_address_i[VA_W-1:12];

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && tlb_page_q[i] == req_page) begin
        hit_any = 1'b1;
        hit_idx = TLB_IDX_W'(i);
      end
    end
  end

  // A level outside one..four is treated as the last level
  assign lvl = (walk_level_q >= LEVEL_1 && walk_level_q <= LEVEL_4) ? walk_level_q : LEVEL_1;
  assign next_level = lvl - LEVEL_1;
  assign leaf_pa = {pte_data_i[PA_W-1:12], 12'd0} |
                   {{(PA_W-VA_W){1'b0}}, level_offset(walk_addr_q, lvl)};

  always_comb begin
    res_valid    = 1'b0;
    kind_d       = KIND_READ;
    base_d       = '0;
    index_d      = '0;
    pa_d         = '0;
    code_d       = FAULT_NONE;
    level_d      = LEVEL_TLB;
    hit_d        = 1'b0;
    tlb_valid_d  = tlb_valid_q;
    fill_en      = 1'b0;
    walk_start   = 1'b0;
    walk_busy_d  = walk_busy_q;
    walk_level_d = walk_level_q;
    perm_code    = FAULT_NONE;

    if (in_accept) begin
      case (action_i)
        ACT_FLUSH: begin
          tlb_valid_d = '0;
        end
        ACT_TRANSLATE: begin
          if (!walk_busy_q) begin
            res_valid = 1'b1;
            if (hit_any) begin
              hit_d     = 1'b1;
              perm_code = check_perm(tlb_perm_q[hit_idx], is_write_i, is_user_i);
              if (perm_code != FAULT_NONE) begin
                kind_d = KIND_FAULT;
                code_d = perm_code;
              end else begin
                kind_d = KIND_DONE;
                pa_d   = {tlb_frame_q[hit_idx], virtual_address_i[11:0]};
              end
            end else begin
              walk_start   = 1'b1;
              walk_busy_d  = 1'b1;
              walk_level_d = LEVEL_4;
              kind_d       = KIND_READ;
              base_d       = root_q;
              index_d      = level_index(virtual_address_i, LEVEL_4);
            end
          end
        end
        ACT_PTE: begin
          if (walk_busy_q) begin
            res_valid = 1'b1;
            perm_code = check_perm(pte_data_i[2:0], walk_write_q, walk_user_q);
            if (perm_code != FAULT_NONE) begin
              walk_busy_d = 1'b0;
              kind_d      = KIND_FAULT;
              code_d      = perm_code;
              level_d     = lvl;
            end else if (lvl == LEVEL_1 || pte_data_i[PTE_HUGE]) begin
              walk_busy_d = 1'b0;
              fill_en     = 1'b1;
              kind_d      = KIND_DONE;
              pa_d        = leaf_pa;
            end else begin
              walk_level_d = next_level;
              kind_d       = KIND_READ;
              base_d       = {pte_data_i[PA_W-1:12], 12'd0};
              index_d      = level_index(walk_addr_q, next_level);
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (fill_en) tlb_valid_d[victim_q] = 1'b1;
    victim_d = victim_q;
    if (fill_en) begin
      victim_d = (victim_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : victim_q + 1'b1;
    end

    out_valid_d = out_valid_q & out_stall_i;
    if (res_valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q       <= '0;
      tlb_valid_q  <= '0;
      victim_q     <= '0;
      walk_busy_q  <= 1'b0;
      walk_level_q <= LEVEL_TLB;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) root_q <= root_table_base_i;
      tlb_valid_q  <= tlb_valid_d;
      victim_q     <= victim_d;
      walk_busy_q  <= walk_busy_d;
      walk_level_q <= walk_level_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (walk_start) begin
      walk_addr_q  <= virtual_address_i;
      walk_write_q <= is_write_i;
      walk_user_q  <= is_user_i;
    end
    if (fill_en) begin
      tlb_page_q[victim_q]  <= walk_addr_q[VA_W-1:12];
      tlb_frame_q[victim_q] <= leaf_pa[PA_W-1:12];
      tlb_perm_q[victim_q]  <= pte_data_i[2:0];
    end
    if (res_valid) begin
      kind_q  <= kind_d;
      base_q  <= base_d;
      index_q <= index_d;
      pa_q    <= pa_d;
      code_q  <= code_d;
      level_q <= level_d;
      hit_q   <= hit_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign read_table_base_o  = base_q;
  assign read_index_o       = index_q;
  assign physical_address_o = pa_q;
  assign fault_code_o       = code_q;
  assign fault_level_o      = level_q;
  assign tlb_hit_o          = hit_q;

  `PW_ASSERT(a_fault_has_code, out_valid_q && kind_q == KIND_FAULT |-> code_q != FAULT_NONE, "fault beat without a fault code")
  `PW_ASSERT(a_read_while_walking, out_valid_q && kind_q == KIND_READ |-> walk_busy_q, "read request shown with no walk in flight")
  `PW_ASSERT(a_hit_not_read, out_valid_q && hit_q |-> kind_q != KIND_READ, "TLB hit produced a read request")
  `PW_ASSERT(a_walk_level_range, walk_busy_q |-> walk_level_q >= LEVEL_1 && walk_level_q <= LEVEL_4, "walk level out of range")
  `PW_ASSERT(a_walk_fault_level, out_valid_q && kind_q == KIND_FAULT && !hit_q |-> level_q != LEVEL_TLB, "walk fault without a table level")

endmodule
